// ===== hw/rtl/wco_pkg.sv =====
// Shared constants, codes and types of the wavetable chord oscillator.
package wco_pkg;

  localparam int TABLE_SIZE_DEF = 512;
  localparam int MAX_VOICES_DEF = 8;

  localparam int SAMPLE_W = 16;  // Q1.15 table value and output sample
  localparam int INC_W    = 24;  // Q8.16 phase increment
  localparam int FRAC_W   = 16;  // fraction bits of a phase
  localparam int CNT_W    = 24;  // chord sample counter
  localparam int VC_W     = 4;   // voice count register
  localparam int VOICE_W  = 3;   // voice field of an input item
  localparam int CFG_W    = 24;  // widest configuration register

  // pi in Q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef enum logic {
    CFG_VOICE_COUNT   = 1'b0,
    CFG_CHORD_SAMPLES = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

// ===== hw/rtl/wco_sine_rom.sv =====
// Sine lookup ROM with registered read, table built at elaboration.
module wco_sine_rom #(
  parameter int TABLE_SIZE = wco_pkg::TABLE_SIZE_DEF
) (
  input  logic                                 clk_i,
  input  logic [$clog2(TABLE_SIZE)-1:0]        addr_i,
  output logic signed [wco_pkg::SAMPLE_W-1:0]  data_o
);
  import wco_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] rom_t [TABLE_SIZE];

  // Taylor series divisors (2k)(2k+1), k = 1..10
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };
  localparam logic [63:0] TableLen = 64'(TABLE_SIZE);

  // round(32767 * sin(2*pi*i/TABLE_SIZE)) in Q2.30 integer arithmetic
  function automatic logic signed [SAMPLE_W-1:0] sine_val(input int unsigned i);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        mag;
    logic               neg;
    int unsigned        k;
    a   = (64'd2 * PI_Q30 * 64'(i) + TableLen / 64'd2) / TableLen;
    neg = 1'b0;
    if (a >= PI_Q30) begin
      a   = a - PI_Q30;
      neg = 1'b1;
    end
    if (a > PI_Q30 / 64'd2) begin
      a = PI_Q30 - a;
    end
    a2   = (a * a) >> 30;
    term = a;
    sum  = signed'(a);
    for (k = 1; k <= 10; k++) begin
      term = ((term * a2) >> 30) / TAYLOR_DIV[k-1];
      if (k[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return neg ? -signed'(SAMPLE_W'(mag)) : signed'(SAMPLE_W'(mag));
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      t[i] = sine_val(i);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SINE_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/wco_voice_mem.sv =====
// Per-voice increment and phase memory, one write and one registered read port.
module wco_voice_mem #(
  parameter int MAX_VOICES = wco_pkg::MAX_VOICES_DEF,
  parameter int PHASE_W    = 25,
  parameter int VW         = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [VW-1:0]             waddr_i,
  input  logic [wco_pkg::INC_W-1:0] winc_i,
  input  logic [PHASE_W-1:0]        wphase_i,
  input  logic                      re_i,
  input  logic [VW-1:0]             raddr_i,
  output logic [wco_pkg::INC_W-1:0] rinc_o,
  output logic [PHASE_W-1:0]        rphase_o
);
  import wco_pkg::*;

  localparam int ENTRY_W = INC_W + PHASE_W;

  logic [ENTRY_W-1:0]    mem_q [MAX_VOICES];
  logic [MAX_VOICES-1:0] valid_q;
  logic [ENTRY_W-1:0]    rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {winc_i, wphase_i};
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Entries never loaded read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rinc_o   = rvalid_q ? rdata_q[ENTRY_W-1:PHASE_W] : '0;
  assign rphase_o = rvalid_q ? rdata_q[PHASE_W-1:0] : '0;

endmodule

// ===== hw/rtl/wco_div.sv =====
// Bit-serial signed divider by a small voice count, truncating toward zero.
module wco_div #(
  parameter int SUM_W = 19,
  parameter int NW    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [SUM_W-1:0]             sum_i,
  input  logic [NW-1:0]                       divisor_i,
  output logic                                done_o,
  output logic signed [wco_pkg::SAMPLE_W-1:0] quot_o
);
  import wco_pkg::*;

  localparam int MW    = SUM_W - 1;
  localparam int CNT_B = $clog2(MW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_B-1:0] cnt_q;
  logic [MW-1:0]    mag_q;   // dividend bits shift out, quotient bits shift in
  logic [NW-1:0]    rem_q;
  logic [NW-1:0]    div_q;
  logic             neg_q;

  logic [SUM_W-1:0] sum_abs;
  logic [NW:0]      rem_sh;
  logic             fits;
  logic signed [MW:0] q_signed;

  assign sum_abs  = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
  assign rem_sh   = {rem_q, mag_q[MW-1]};
  assign fits     = rem_sh >= {1'b0, div_q};
  assign q_signed = neg_q ? -signed'({1'b0, mag_q}) : signed'({1'b0, mag_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_B'(MW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= sum_abs[MW-1:0];
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= sum_i[SUM_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? NW'(rem_sh - {1'b0, div_q}) : NW'(rem_sh);
      mag_q <= {mag_q[MW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = SAMPLE_W'(q_signed);

endmodule

// ===== hw/rtl/wavetable_chord_oscillator_core.sv =====
// Top level of the multi-voice wavetable chord oscillator.
//
// Usage: input beats arrive on s_axis_*. tuser selects the kind of beat:
// a load (tuser 0) writes one voice's Q8.16 increment, sets its phase to the
// increment and restarts the chord counter; a tick (tuser 1) asks for one
// sample. Samples leave on m_axis_* as signed Q1.15 in tdata, with tlast
// high on the chord's last sample. A tick after the chord is complete, and
// every load, produce no output beat.
// Voice count and chord length are set on the cfg_* port; the user must
// write them only while idle, as the block itself does not enforce it.
// A tick reads its N active voices from the voice memory port, one voice a
// cycle, then a serial divider produces one quotient bit per cycle from the
// SUM_W-bit sum (SUM_W = 16 + log2(MAX_VOICES)). One item at a time: no new
// beat is taken until the previous one is finished.
// Reset clears the voice memory (all voices zero), the counter, one voice
// and a zero-length chord. A stalled output holds its beat in the output
// register; the block still takes the next item and stops only when a new
// sample is ready while the previous one has not been taken.
module wavetable_chord_oscillator_core #(
  parameter int TABLE_SIZE = wco_pkg::TABLE_SIZE_DEF,  // power of two
  parameter int MAX_VOICES = wco_pkg::MAX_VOICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,   // [2:0] voice, [26:3] increment
  input  logic                          s_axis_tuser,   // [0] func
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [15:0] sample
  output logic                          m_axis_tlast,   // chord_end
  // configuration writes
  input  logic                          cfg_we_i,
  input  wco_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [wco_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import wco_pkg::*;

  localparam int TW      = $clog2(TABLE_SIZE);
  localparam int PHASE_W = TW + FRAC_W;
  localparam int VW      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int NW      = $clog2(MAX_VOICES + 1);
  localparam int SUM_W   = SAMPLE_W + $clog2(MAX_VOICES);

  // configuration
  logic [VC_W-1:0]  voice_count_q;
  logic [CNT_W-1:0] chord_samples_q;

  // control
  state_e           state_q, state_d;
  logic [CNT_W-1:0] done_cnt_q, done_cnt_d;
  logic [NW-1:0]    nvoices_q, nvoices_d;
  logic [NW-1:0]    rd_cnt_q, rd_cnt_d;
  logic             rd_pend_q, rom_pend_q;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;

  // datapath
  logic signed [SUM_W-1:0]    acc_q, acc_d;
  logic [VW-1:0]              wb_addr_q;
  logic signed [SAMPLE_W-1:0] out_data_q, out_data_d;
  logic                       out_last_q, out_last_d;
  logic                       out_load;

  // input fields
  func_e              in_func;
  logic [VOICE_W-1:0] in_voice;
  logic [INC_W-1:0]   in_inc;
  logic               in_acc;

  // memory, ROM and divider hookup
  logic               mem_we, mem_re;
  logic [VW-1:0]      mem_waddr;
  logic [INC_W-1:0]   mem_winc, mem_rinc;
  logic [PHASE_W-1:0] mem_wphase, mem_rphase, phase_nxt;
  logic signed [SAMPLE_W-1:0] rom_data;
  logic               div_start, div_done;
  logic signed [SAMPLE_W-1:0] div_quot;
  logic [NW-1:0]      active_n;

  assign in_func  = func_e'(s_axis_tuser);
  assign in_voice = s_axis_tdata[VOICE_W-1:0];
  assign in_inc   = s_axis_tdata[VOICE_W +: INC_W];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // A voice count of zero means one voice; clamp at the voice limit.
  always_comb begin
    if (voice_count_q == '0) begin
      active_n = NW'(1);
    end else if (32'(voice_count_q) > MAX_VOICES) begin
      active_n = NW'(MAX_VOICES);
    end else begin
      active_n = NW'(voice_count_q);
    end
  end

  // Advance wraps modulo the table length in phase units.
  assign phase_nxt = mem_rphase + PHASE_W'(mem_rinc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_count_q   <= VC_W'(1);
      chord_samples_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VOICE_COUNT:   voice_count_q   <= cfg_wdata_i[VC_W-1:0];
        CFG_CHORD_SAMPLES: chord_samples_q <= cfg_wdata_i[CNT_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_cnt_q  <= '0;
      nvoices_q   <= '0;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      rom_pend_q  <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_cnt_q  <= done_cnt_d;
      nvoices_q   <= nvoices_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_pend_q   <= mem_re;
      rom_pend_q  <= rd_pend_q;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    if (mem_re) begin
      wb_addr_q <= rd_cnt_q[VW-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    done_cnt_d = done_cnt_q;
    nvoices_d  = nvoices_q;
    rd_cnt_d   = rd_cnt_q;
    last_d     = last_q;
    acc_d      = acc_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    out_load   = 1'b0;

    s_axis_tready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = wb_addr_q;
    mem_winc   = mem_rinc;
    mem_wphase = phase_nxt;
    mem_re     = 1'b0;
    div_start  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          if (in_func == FUNC_LOAD) begin
            // drop loads to voices past the limit
            if (32'(in_voice) < MAX_VOICES) begin
              mem_we     = 1'b1;
              mem_waddr  = VW'(in_voice);
              mem_winc   = in_inc;
              mem_wphase = PHASE_W'(in_inc);
              done_cnt_d = '0;
            end
          end else if (done_cnt_q < chord_samples_q) begin
            last_d     = ((CNT_W+1)'(done_cnt_q) + 1'b1) == (CNT_W+1)'(chord_samples_q);
            done_cnt_d = done_cnt_q + 1'b1;
            nvoices_d  = active_n;
            rd_cnt_d   = '0;
            acc_d      = '0;
            state_d    = ST_READ;
          end
        end
      end

      ST_READ: begin
        // read one voice a cycle, write its advanced phase back in the next cycle
        if (rd_cnt_q < nvoices_q) begin
          mem_re   = 1'b1;
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        if (rd_pend_q) begin
          mem_we = 1'b1;
        end
        if (rom_pend_q) begin
          acc_d = acc_q + SUM_W'(rom_data);
        end
        if (rd_cnt_q == nvoices_q && !rd_pend_q && !rom_pend_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_load   = 1'b1;
          out_data_d = div_quot;
          out_last_d = last_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  wco_voice_mem #(
    .MAX_VOICES (MAX_VOICES),
    .PHASE_W    (PHASE_W),
    .VW         (VW)
  ) u_voice_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .winc_i   (mem_winc),
    .wphase_i (mem_wphase),
    .re_i     (mem_re),
    .raddr_i  (rd_cnt_q[VW-1:0]),
    .rinc_o   (mem_rinc),
    .rphase_o (mem_rphase)
  );

  wco_sine_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (mem_rphase[PHASE_W-1:FRAC_W]),
    .data_o (rom_data)
  );

  wco_div #(
    .SUM_W (SUM_W),
    .NW    (NW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (acc_q),
    .divisor_i (nvoices_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
